@@ hw/rtl/quaternion_to_euler_angles_unit_assert.svh @@
// Assertion macros used by the quaternion to Euler angles unit.
`ifndef QUATERNION_TO_EULER_ANGLES_UNIT_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define QTE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define QTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QTE_ASSERT_IMP(lbl, ante, cons, msg)
`define QTE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hw/rtl/qte_pkg.sv @@
// Types, constants and arithmetic helpers of the quaternion to Euler angles unit.
package qte_pkg;

    localparam int QUAT_BITS     = 16;
    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = QUAT_BITS - 2;
    localparam int GUARD_BITS    = 8;
    localparam int PROD_W        = 2 * QUAT_BITS - FRAC_BITS;
    localparam int SUM_W         = PROD_W + 2;
    localparam int SQ_W          = 2 * FRAC_BITS + 2;
    localparam int SQRT_STEPS    = FRAC_BITS + 1;
    localparam int CX_W          = 32;
    localparam int CZ_W          = 34;
    localparam int ATAN_ROWS     = 24;
    localparam int ANGLE_SHIFT   = 32 - ANGLE_BITS;

    // Pipeline stage positions.
    localparam int ST_PROD    = 0;
    localparam int ST_SUM     = 1;
    localparam int ST_REM     = 2;
    localparam int ST_CORDIC0 = ST_REM + SQRT_STEPS + 1;
    localparam int PIPE_DEPTH = ST_CORDIC0 + CORDIC_STAGES + 2;
    localparam int ST_OUT     = PIPE_DEPTH - 1;

    localparam logic signed [SUM_W-1:0] ONE_FIX = SUM_W'(1) <<< FRAC_BITS;
    localparam logic signed [CZ_W-1:0] HALF_PI_UNITS = 34'sd1073741824;
    localparam logic signed [CZ_W-1:0] ROUND_HALF = CZ_W'(1) <<< (ANGLE_SHIFT - 1);
    localparam logic signed [ANGLE_BITS-1:0] PITCH_POS_LIMIT = ANGLE_BITS'(1) <<< (ANGLE_BITS - 2);

    // atan(2^-i), pi = 2^31.
    localparam logic signed [CZ_W-1:0] ATAN_TAB [ATAN_ROWS] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
        34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
        34'sd652,       34'sd326,       34'sd163,       34'sd81
    };

    typedef struct packed {
        logic signed [PROD_W-1:0] wx;
        logic signed [PROD_W-1:0] yz;
        logic signed [PROD_W-1:0] xx;
        logic signed [PROD_W-1:0] yy;
        logic signed [PROD_W-1:0] wz;
        logic signed [PROD_W-1:0] xy;
        logic signed [PROD_W-1:0] zz;
        logic signed [PROD_W-1:0] wy;
        logic signed [PROD_W-1:0] zx;
    } prod_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sr;
        logic signed [SUM_W-1:0] cr;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] cy;
        logic signed [SUM_W-1:0] s;
        logic                    sat;
    } sum_t;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
        logic                   zero;
    } cordic_lane_t;

    // One restoring square root step with trial bit 4^e.
    function automatic logic [2*SQ_W-1:0] sqrt_step(logic [SQ_W-1:0] n, logic [SQ_W-1:0] r,
                                                    logic [4:0] e);
        logic [SQ_W-1:0] b;
        logic [SQ_W-1:0] t;
        b = SQ_W'(1) << {e, 1'b0};
        t = r + b;
        if (n >= t)
            return {n - t, (r >> 1) + b};
        return {n, r >> 1};
    endfunction

    // Scale up and fold the left half plane into the right one.
    function automatic cordic_lane_t cordic_start(logic signed [SUM_W-1:0] y_in,
                                                  logic signed [SUM_W-1:0] x_in);
        cordic_lane_t l;
        logic signed [CX_W-1:0] xs;
        logic signed [CX_W-1:0] ys;
        xs = CX_W'(x_in) <<< GUARD_BITS;
        ys = CX_W'(y_in) <<< GUARD_BITS;
        l.zero = (x_in == '0) && (y_in == '0);
        if (xs < 0) begin
            if (ys >= 0) begin
                l.x = ys;
                l.y = -xs;
                l.z = HALF_PI_UNITS;
            end else begin
                l.x = -ys;
                l.y = xs;
                l.z = -HALF_PI_UNITS;
            end
        end else begin
            l.x = xs;
            l.y = ys;
            l.z = '0;
        end
        return l;
    endfunction

    function automatic cordic_lane_t cordic_iter(cordic_lane_t l, logic [4:0] i);
        cordic_lane_t o;
        logic signed [CX_W-1:0] xs;
        logic signed [CX_W-1:0] ys;
        xs = l.x >>> i;
        ys = l.y >>> i;
        o.zero = l.zero;
        if (l.y >= 0) begin
            o.x = l.x + ys;
            o.y = l.y - xs;
            o.z = l.z + ATAN_TAB[i];
        end else begin
            o.x = l.x - ys;
            o.y = l.y + xs;
            o.z = l.z - ATAN_TAB[i];
        end
        return o;
    endfunction

    function automatic logic signed [ANGLE_BITS-1:0] to_angle(cordic_lane_t l);
        logic signed [CZ_W-1:0] t;
        t = l.z + ROUND_HALF;
        if (l.zero)
            return '0;
        return t[ANGLE_SHIFT +: ANGLE_BITS];
    endfunction

endpackage

@@ hw/rtl/quaternion_to_euler_angles_unit.sv @@
// Top level of the quaternion to roll, pitch and yaw converter.
//
// One quaternion (quat_w, quat_x, quat_y, quat_z, signed Q2.14) enters per
// transaction on the in_valid / in_ready channel; one result (roll_angle,
// pitch_angle, yaw_angle in binary angle units where 32768 is pi, and
// pitch_saturated) leaves per transaction on the out_valid / out_ready channel.
// The datapath is a 36-stage pipeline: products, sums, the 1-s^2 remainder,
// fifteen square root stages (one result bit each), a half plane fold and
// sixteen CORDIC stages shared in step by the three angles, and a rounding
// stage. One transaction is taken every cycle unless the pipeline is full and the receiver stalls.
// Every stage has its own valid bit and loads when it is empty or when the
// stage after it moves, so bubbles are squeezed out while the receiver
// stalls and in_ready falls only when all 36 stages hold results.
// Reset clears every valid bit; the pipeline is empty afterward.
`include "quaternion_to_euler_angles_unit_assert.svh"

module quaternion_to_euler_angles_unit
    import qte_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [QUAT_BITS-1:0]  quat_w,
    input  logic signed [QUAT_BITS-1:0]  quat_x,
    input  logic signed [QUAT_BITS-1:0]  quat_y,
    input  logic signed [QUAT_BITS-1:0]  quat_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [ANGLE_BITS-1:0] roll_angle,
    output logic signed [ANGLE_BITS-1:0] pitch_angle,
    output logic signed [ANGLE_BITS-1:0] yaw_angle,
    output logic                         pitch_saturated
);

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] stage_en;

    prod_t                       prod_reg;
    sum_t                        sum_reg;
    logic [SQ_W-1:0]             sqn_reg [SQRT_STEPS+1];
    logic [SQ_W-1:0]             sqr_reg [SQRT_STEPS+1];
    sum_t                        sqc_reg [SQRT_STEPS+1];
    cordic_lane_t                roll_reg  [CORDIC_STAGES+1];
    cordic_lane_t                pitch_reg [CORDIC_STAGES+1];
    cordic_lane_t                yaw_reg   [CORDIC_STAGES+1];
    logic                        csat_reg  [CORDIC_STAGES+1];
    logic                        cneg_reg  [CORDIC_STAGES+1];
    logic signed [ANGLE_BITS-1:0] roll_out_reg;
    logic signed [ANGLE_BITS-1:0] pitch_out_reg;
    logic signed [ANGLE_BITS-1:0] yaw_out_reg;
    logic                        sat_out_reg;

    prod_t                       prod_next;
    sum_t                        sum_next;
    logic [FRAC_BITS-1:0]        s_mag;
    logic [2*FRAC_BITS-1:0]      s_sq;
    logic signed [SUM_W-1:0]     s_abs;

    // A stage loads when it is empty or when the stage after it moves on.
    assign stage_en[ST_OUT] = !valid_reg[ST_OUT] || out_ready;
    for (genvar k = 0; k < ST_OUT; k++) begin : g_en
        assign stage_en[k] = !valid_reg[k] || stage_en[k+1];
    end

    assign in_ready        = stage_en[ST_PROD];
    assign out_valid       = valid_reg[ST_OUT];
    assign roll_angle      = roll_out_reg;
    assign pitch_angle     = pitch_out_reg;
    assign yaw_angle       = yaw_out_reg;
    assign pitch_saturated = sat_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[ST_PROD])
                valid_reg[ST_PROD] <= in_valid;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (stage_en[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Products floored to the component's fraction bits.
    function automatic logic signed [PROD_W-1:0] fmul(logic signed [QUAT_BITS-1:0] a,
                                                      logic signed [QUAT_BITS-1:0] b);
        logic signed [2*QUAT_BITS-1:0] p;
        p = a * b;
        return p[2*QUAT_BITS-1:FRAC_BITS];
    endfunction

    always_comb
    begin
        prod_next.wx = fmul(quat_w, quat_x);
        prod_next.yz = fmul(quat_y, quat_z);
        prod_next.xx = fmul(quat_x, quat_x);
        prod_next.yy = fmul(quat_y, quat_y);
        prod_next.wz = fmul(quat_w, quat_z);
        prod_next.xy = fmul(quat_x, quat_y);
        prod_next.zz = fmul(quat_z, quat_z);
        prod_next.wy = fmul(quat_w, quat_y);
        prod_next.zx = fmul(quat_z, quat_x);
    end

    always_comb
    begin
        sum_next.sr = (SUM_W'(prod_reg.wx) + SUM_W'(prod_reg.yz)) <<< 1;
        sum_next.cr = ONE_FIX - ((SUM_W'(prod_reg.xx) + SUM_W'(prod_reg.yy)) <<< 1);
        sum_next.sy = (SUM_W'(prod_reg.wz) + SUM_W'(prod_reg.xy)) <<< 1;
        sum_next.cy = ONE_FIX - ((SUM_W'(prod_reg.yy) + SUM_W'(prod_reg.zz)) <<< 1);
        sum_next.s  = (SUM_W'(prod_reg.wy) - SUM_W'(prod_reg.zx)) <<< 1;
        sum_next.sat = (sum_next.s >= ONE_FIX) || (sum_next.s <= -ONE_FIX);
    end

    // Below saturation |s| fits in the fraction bits.
    always_comb
    begin
        s_abs = sum_reg.s[SUM_W-1] ? -sum_reg.s : sum_reg.s;
        s_mag = s_abs[FRAC_BITS-1:0];
        s_sq  = s_mag * s_mag;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[ST_PROD])
            prod_reg <= prod_next;
        if (stage_en[ST_SUM])
            sum_reg <= sum_next;
        if (stage_en[ST_REM]) begin
            sqn_reg[0] <= (SQ_W'(1) << (2 * FRAC_BITS)) - SQ_W'(s_sq);
            sqr_reg[0] <= '0;
            sqc_reg[0] <= sum_reg;
        end
    end

    for (genvar j = 1; j <= SQRT_STEPS; j++) begin : g_sqrt
        always_ff @(posedge clk)
        begin
            if (stage_en[ST_REM+j]) begin
                {sqn_reg[j], sqr_reg[j]} <= sqrt_step(sqn_reg[j-1], sqr_reg[j-1],
                                                      5'(SQRT_STEPS - j));
                sqc_reg[j] <= sqc_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[ST_CORDIC0]) begin
            roll_reg[0]  <= cordic_start(sqc_reg[SQRT_STEPS].sr, sqc_reg[SQRT_STEPS].cr);
            yaw_reg[0]   <= cordic_start(sqc_reg[SQRT_STEPS].sy, sqc_reg[SQRT_STEPS].cy);
            pitch_reg[0] <= cordic_start(sqc_reg[SQRT_STEPS].s,
                                         sqr_reg[SQRT_STEPS][SUM_W-1:0]);
            csat_reg[0]  <= sqc_reg[SQRT_STEPS].sat;
            cneg_reg[0]  <= sqc_reg[SQRT_STEPS].s[SUM_W-1];
        end
    end

    for (genvar m = 1; m <= CORDIC_STAGES; m++) begin : g_cordic
        always_ff @(posedge clk)
        begin
            if (stage_en[ST_CORDIC0+m]) begin
                roll_reg[m]  <= cordic_iter(roll_reg[m-1], 5'(m - 1));
                pitch_reg[m] <= cordic_iter(pitch_reg[m-1], 5'(m - 1));
                yaw_reg[m]   <= cordic_iter(yaw_reg[m-1], 5'(m - 1));
                csat_reg[m]  <= csat_reg[m-1];
                cneg_reg[m]  <= cneg_reg[m-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[ST_OUT]) begin
            roll_out_reg <= to_angle(roll_reg[CORDIC_STAGES]);
            yaw_out_reg  <= to_angle(yaw_reg[CORDIC_STAGES]);
            sat_out_reg  <= csat_reg[CORDIC_STAGES];
            if (csat_reg[CORDIC_STAGES])
                pitch_out_reg <= cneg_reg[CORDIC_STAGES] ? -PITCH_POS_LIMIT : PITCH_POS_LIMIT;
            else
                pitch_out_reg <= to_angle(pitch_reg[CORDIC_STAGES]);
        end
    end

    `QTE_ASSERT_IMP(a_full_when_blocked, !in_ready, out_valid && !out_ready,
                    "input blocked while the pipeline has room")
    `QTE_ASSERT_NEXT(a_accept_lands, in_valid && in_ready, valid_reg[ST_PROD],
                     "accepted transaction did not enter the first stage")
    `QTE_ASSERT_IMP(a_root_range,
                    valid_reg[ST_CORDIC0-1] && !sqc_reg[SQRT_STEPS].sat,
                    sqr_reg[SQRT_STEPS] <= (SQ_W'(1) << FRAC_BITS),
                    "square root exceeds one")
    `QTE_ASSERT_IMP(a_sat_pitch, out_valid && pitch_saturated,
                    pitch_angle == PITCH_POS_LIMIT || pitch_angle == -PITCH_POS_LIMIT,
                    "saturated pitch is not a right angle")

endmodule

@@ tb/sv/quaternion_to_euler_angles_unit_tb.sv @@
// Self-checking testbench for the quaternion to roll, pitch and yaw converter.
`timescale 1ns / 100ps

module quaternion_to_euler_angles_unit_tb;
    import qte_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 2 * PIPE_DEPTH;
    localparam int HOLD_CYCLES    = 150;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] roll;
        logic signed [ANGLE_BITS-1:0] pitch;
        logic signed [ANGLE_BITS-1:0] yaw;
        logic                         sat;
    } euler_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [QUAT_BITS-1:0] quat_w;
    logic signed [QUAT_BITS-1:0] quat_x;
    logic signed [QUAT_BITS-1:0] quat_y;
    logic signed [QUAT_BITS-1:0] quat_z;
    logic out_valid;
    logic out_ready;
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
    logic pitch_saturated;

    euler_t expected_angles[$];
    int     error_count = 0;
    bit     no_idle = 0;
    int     hold_request = 0;
    int     hold_served = 0;
    int     hold_left = 0;
    int     quiet_cycles = 0;

    quaternion_to_euler_angles_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle),
        .yaw_angle(yaw_angle), .pitch_saturated(pitch_saturated)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Vectoring CORDIC; the result is in units where pi is 2^31.
    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint t;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        x = x * (longint'(1) << GUARD_BITS);
        y = y * (longint'(1) << GUARD_BITS);
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = longint'(1) << 30;
            end
            else
            begin
                x = -y;
                y = t;
                z = -(longint'(1) << 30);
            end
        end
        for (int i = 0; i < CORDIC_STAGES && i < ATAN_ROWS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TAB[i]);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] binary_angle(longint z);
        longint r;
        r = (z + (longint'(1) << (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
        return r[ANGLE_BITS-1:0];
    endfunction

    function automatic euler_t quat_to_euler(logic signed [QUAT_BITS-1:0] qw,
                                             logic signed [QUAT_BITS-1:0] qx,
                                             logic signed [QUAT_BITS-1:0] qy,
                                             logic signed [QUAT_BITS-1:0] qz);
        longint w, x, y, z, one, sr, cr, sy, cy, s, c;
        euler_t e;
        w = qw; x = qx; y = qy; z = qz;
        one = longint'(1) << FRAC_BITS;
        sr = 2 * (floor_shift(w * x, FRAC_BITS) + floor_shift(y * z, FRAC_BITS));
        cr = one - 2 * (floor_shift(x * x, FRAC_BITS) + floor_shift(y * y, FRAC_BITS));
        sy = 2 * (floor_shift(w * z, FRAC_BITS) + floor_shift(x * y, FRAC_BITS));
        cy = one - 2 * (floor_shift(y * y, FRAC_BITS) + floor_shift(z * z, FRAC_BITS));
        s  = 2 * (floor_shift(w * y, FRAC_BITS) - floor_shift(z * x, FRAC_BITS));
        e.roll = binary_angle(vector_angle(sr, cr));
        if (s >= one || s <= -one)
        begin
            e.pitch = binary_angle(s > 0 ? (longint'(1) << 30) : -(longint'(1) << 30));
            e.sat = 1'b1;
        end
        else
        begin
            c = int_sqrt((longint'(1) << (2 * FRAC_BITS)) - s * s);
            e.pitch = binary_angle(vector_angle(s, c));
            e.sat = 1'b0;
        end
        e.yaw = binary_angle(vector_angle(sy, cy));
        return e;
    endfunction

    // Records the expected angles of every accepted input transaction.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            expected_angles.push_back(quat_to_euler(quat_w, quat_x, quat_y, quat_z));
    end

    always @(posedge clk)
    begin
        euler_t exp_e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_angles.size() == 0)
            begin
                $display("%0t: unexpected result roll=%0d pitch=%0d yaw=%0d sat=%0d",
                         $time, roll_angle, pitch_angle, yaw_angle, pitch_saturated);
                error_count++;
            end
            else
            begin
                exp_e = expected_angles.pop_front();
                if (roll_angle !== exp_e.roll)
                begin
                    $display("%0t: roll expected %0d actual %0d", $time, exp_e.roll,
                             roll_angle);
                    error_count++;
                end
                if (pitch_angle !== exp_e.pitch)
                begin
                    $display("%0t: pitch expected %0d actual %0d", $time, exp_e.pitch,
                             pitch_angle);
                    error_count++;
                end
                if (yaw_angle !== exp_e.yaw)
                begin
                    $display("%0t: yaw expected %0d actual %0d", $time, exp_e.yaw,
                             yaw_angle);
                    error_count++;
                end
                if (pitch_saturated !== exp_e.sat)
                begin
                    $display("%0t: pitch_saturated expected %0d actual %0d", $time,
                             exp_e.sat, pitch_saturated);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here on request.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_request != hold_served)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            hold_served <= hold_request;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            out_ready <= no_idle || ($urandom_range(0, 99) >= 14);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL quaternion_to_euler_angles_unit");
            $finish;
        end
    end

    task automatic send_quat(logic signed [QUAT_BITS-1:0] w, logic signed [QUAT_BITS-1:0] x,
                             logic signed [QUAT_BITS-1:0] y, logic signed [QUAT_BITS-1:0] z);
        if (!no_idle && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        quat_w <= w;
        quat_x <= x;
        quat_y <= y;
        quat_z <= z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_angles.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_random(int count, bit unit_range);
        logic signed [QUAT_BITS-1:0] q[4];
        for (int n = 0; n < count; n++)
        begin
            for (int k = 0; k < 4; k++)
                q[k] = unit_range && ($urandom_range(0, 3) != 0)
                       ? QUAT_BITS'($signed($urandom_range(0, 2 * 16384)) - 16384)
                       : QUAT_BITS'($urandom());
            send_quat(q[0], q[1], q[2], q[3]);
        end
    endtask

    task automatic test_directed();
        send_quat(0, 0, 0, 0);
        send_quat(16384, 0, 0, 0);
        send_quat(-16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);          // roll of exactly pi wraps to -pi
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(11585, 0, 11585, 0);      // pitch at +pi/2
        send_quat(11585, 0, -11585, 0);     // pitch at -pi/2
        send_quat(11586, 0, 11586, 0);
        send_quat(0, 11585, 0, 11585);
        send_quat(32767, 32767, 32767, 32767);
        send_quat(-32768, -32768, -32768, -32768);
        send_quat(32767, -32768, 32767, -32768);
        send_quat(-32768, 32767, -32768, 32767);
        send_quat(8192, 8192, 8192, 8192);
        send_quat(8192, -8192, 8192, -8192);
        send_quat(1, -1, 1, -1);
        send_quat(0, 12000, 12000, 0);      // left half plane, y not negative
        send_quat(3000, -14000, 2000, 7000); // left half plane, y negative
        send_quat(14189, 8192, 0, 0);
        send_quat(0, 0, 0, -32768);
        wait_for_results();
    endtask

    task automatic test_random();
        send_random(300, 1'b1);
        no_idle = 1;
        send_random(200, 1'b0);
        no_idle = 0;
        send_random(300, 1'b1);
        wait_for_results();
    endtask

    task automatic test_backpressure();
        @(posedge clk);
        hold_request <= hold_request + 1;
        send_random(100, 1'b1);
        wait_for_results();
    endtask

    task automatic test_pause();
        send_random(25, 1'b1);
        wait_for_results();
        send_random(25, 1'b0);
        wait_for_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        quat_w = '0;
        quat_x = '0;
        quat_y = '0;
        quat_z = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_backpressure();
        test_pause();
        if (error_count == 0)
            $display("PASS quaternion_to_euler_angles_unit");
        else
            $display("FAIL quaternion_to_euler_angles_unit");
        $finish;
    end

endmodule
